FILE: rtl/mrfd_pkg.sv
package mrfd_pkg;

  // Frame phases of the reply decoder.
  localparam logic [2:0] PH_PREAMBLE = 3'd0;
  localparam logic [2:0] PH_ADDRESS  = 3'd1;
  localparam logic [2:0] PH_START2   = 3'd2;
  localparam logic [2:0] PH_CONTROL  = 3'd3;
  localparam logic [2:0] PH_LENGTH   = 3'd4;
  localparam logic [2:0] PH_DATAID   = 3'd5;
  localparam logic [2:0] PH_DATA     = 3'd6;
  localparam logic [2:0] PH_DISCARD  = 3'd7;

  // Final frame status codes.
  localparam logic [2:0] ST_READ_OK   = 3'd0;
  localparam logic [2:0] ST_SET_OK    = 3'd1;
  localparam logic [2:0] ST_NO_ITEM   = 3'd2;
  localparam logic [2:0] ST_SET_FAIL  = 3'd3;
  localparam logic [2:0] ST_FRAME_ERR = 3'd4;
  localparam logic [2:0] ST_TIMEOUT   = 3'd5;

  // Input word kinds and result word kinds.
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // Frame bytes.
  localparam logic [7:0] START_BYTE  = 8'h68;
  localparam logic [7:0] PRE_FE      = 8'hFE;
  localparam logic [7:0] PRE_00      = 8'h00;
  localparam logic [7:0] CTL_READ_OK = 8'h91;
  localparam logic [7:0] CTL_SET_OK  = 8'h94;
  localparam logic [7:0] CTL_NO_ITEM = 8'hD1;
  localparam logic [7:0] CTL_SET_BAD = 8'hD4;
  localparam logic [7:0] DATA_OFFSET = 8'h33;

  localparam int unsigned ADDR_BYTES   = 6;
  localparam int unsigned DATAID_BYTES = 4;

  localparam int unsigned LIMIT_W = 24;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd100000;

  // Register index of the configuration port.
  localparam logic REG_IDLE_LIMIT = 1'b0;

  // Result of one step of the decoder.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
  } res_t;

endpackage

FILE: rtl/mrfd_core.sv
module mrfd_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic                           op,
  input  logic [7:0]                     rx_byte,
  input  logic [mrfd_pkg::LIMIT_W-1:0]   idle_limit,
  output mrfd_pkg::res_t                 res
);
  import mrfd_pkg::*;

  logic [2:0]         phase_r, phase_nxt;
  logic [2:0]         fpos_r, fpos_nxt;
  logic [7:0]         remain_r, remain_nxt;
  logic [2:0]         class_r, class_nxt;
  logic               seen_r, seen_nxt;
  logic [LIMIT_W-1:0] idle_r, idle_nxt;
  logic [LIMIT_W:0]   idle_inc;
  logic [2:0]         fpos_inc;
  logic [7:0]         remain_dec;
  logic               window_close;

  assign idle_inc     = {1'b0, idle_r} + {{LIMIT_W{1'b0}}, 1'b1};
  assign fpos_inc     = fpos_r + 3'd1;
  assign remain_dec   = remain_r - 8'd1;
  assign window_close = take && (op == OP_TICK) && (idle_inc > {1'b0, idle_limit});

  always_comb begin
    phase_nxt  = phase_r;
    fpos_nxt   = fpos_r;
    remain_nxt = remain_r;
    class_nxt  = class_r;
    seen_nxt   = seen_r;
    idle_nxt   = idle_r;
    res        = '0;
    if (take && op == OP_TICK) begin
      if (window_close) begin
        res.valid  = 1'b1;
        res.kind   = KIND_FINAL;
        res.status = seen_r ? class_r : ST_TIMEOUT;
        phase_nxt  = PH_PREAMBLE;
        fpos_nxt   = '0;
        remain_nxt = '0;
        class_nxt  = ST_FRAME_ERR;
        seen_nxt   = 1'b0;
        idle_nxt   = '0;
      end else begin
        idle_nxt = idle_inc[LIMIT_W-1:0];
      end
    end else if (take) begin
      idle_nxt = '0;
      seen_nxt = 1'b1;
      case (phase_r)
        PH_PREAMBLE: begin
          if (rx_byte == START_BYTE) begin
            phase_nxt = PH_ADDRESS;
            fpos_nxt  = '0;
          end else if (rx_byte != PRE_FE && rx_byte != PRE_00) begin
            phase_nxt = PH_DISCARD;
          end
        end
        PH_ADDRESS: begin
          fpos_nxt = fpos_inc;
          if (fpos_inc >= 3'(ADDR_BYTES)) begin
            fpos_nxt  = '0;
            phase_nxt = PH_START2;
          end
        end
        PH_START2: begin
          phase_nxt = (rx_byte == START_BYTE) ? PH_CONTROL : PH_DISCARD;
        end
        PH_CONTROL: begin
          phase_nxt = PH_DISCARD;
          case (rx_byte)
            CTL_READ_OK: begin
              class_nxt = ST_READ_OK;
              phase_nxt = PH_LENGTH;
            end
            CTL_SET_OK:  class_nxt = ST_SET_OK;
            CTL_NO_ITEM: class_nxt = ST_NO_ITEM;
            CTL_SET_BAD: class_nxt = ST_SET_FAIL;
            default:     class_nxt = ST_FRAME_ERR;
          endcase
        end
        PH_LENGTH: begin
          remain_nxt = (rx_byte >= 8'(DATAID_BYTES)) ? rx_byte - 8'(DATAID_BYTES) : 8'd0;
          fpos_nxt   = '0;
          phase_nxt  = PH_DATAID;
        end
        PH_DATAID: begin
          fpos_nxt = fpos_inc;
          if (fpos_inc >= 3'(DATAID_BYTES)) begin
            fpos_nxt  = '0;
            phase_nxt = (remain_r != 8'd0) ? PH_DATA : PH_DISCARD;
          end
        end
        PH_DATA: begin
          res.valid     = 1'b1;
          res.kind      = KIND_DATA;
          res.data_byte = rx_byte - DATA_OFFSET;
          remain_nxt    = remain_dec;
          if (remain_dec == 8'd0) begin
            phase_nxt = PH_DISCARD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREAMBLE;
      fpos_r   <= '0;
      remain_r <= '0;
      class_r  <= ST_FRAME_ERR;
      seen_r   <= 1'b0;
      idle_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      fpos_r   <= fpos_nxt;
      remain_r <= remain_nxt;
      class_r  <= class_nxt;
      seen_r   <= seen_nxt;
      idle_r   <= idle_nxt;
    end
  end

  // The data phase is only ever entered with bytes still owed.
  a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> remain_r != 8'd0)
    else $error("data phase with no bytes remaining");

  // A closed window leaves every piece of frame state at its reset value.
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    window_close |=> phase_r == PH_PREAMBLE && !seen_r && idle_r == '0
                     && class_r == ST_FRAME_ERR)
    else $error("window close did not restart the decoder");

  // The field counter never runs past the address field.
  a_fpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    fpos_r < 3'(ADDR_BYTES))
    else $error("field position out of range");

  // A data byte result only comes from a received byte in the data phase.
  a_data_source: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind == KIND_DATA |-> phase_r == PH_DATA && op == OP_BYTE)
    else $error("data result outside the data phase");

endmodule

FILE: rtl/meter_reply_frame_decoder.sv
// Reply frame decoder for a DL/T 645 style meter link. Each input word is
// either one received byte (in_tuser low, byte in in_tdata) or one idle tick
// (in_tuser high). The decoder skips 0xFE/0x00 preamble bytes, expects 0x68,
// six address bytes and a second 0x68, classifies the control byte, reads the
// length and skips the four data-id bytes; for a read-ok reply (0x91) each
// following data byte is passed out at once with 0x33 removed. Checksum and
// the 0x16 end byte are not checked, and bytes after the data are ignored.
// When the idle tick count since the last byte exceeds idle_limit, one final
// status word is sent (0 read ok, 1 set ok, 2 no such item, 3 set failed,
// 4 frame error, 5 timeout when no byte arrived at all) and the decoder
// starts afresh. Every input word is handled in the cycle it is accepted and
// its result, if any, appears in the output register on the next cycle, so
// the block takes one word per clock; it stalls only while a result waits in
// the output register and out_tready is low. idle_limit lies at byte address
// 0 of the register port and should be written only while the block is idle.
module meter_reply_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] operation: 0 byte, 1 idle tick
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        out_tuser,  // [0] out_kind: 0 data byte, 1 final status
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mrfd_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic               cfg_write;
  logic               in_accept;
  res_t               res;
  logic               out_valid_r;
  logic               out_kind_r;
  logic [7:0]         out_byte_r;
  logic [2:0]         out_status_r;

  // Registers are word aligned; address bit 2 picks the register.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDLE_LIMIT) ?
                      {{(32-LIMIT_W){1'b0}}, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_write && cfg_paddr[2] == REG_IDLE_LIMIT) begin
      limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  // A new word is taken whenever the output register is empty or is being
  // emptied in this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  mrfd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (in_accept),
    .op         (in_tuser),
    .rx_byte    (in_tdata),
    .idle_limit (limit_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res.valid) begin
      out_kind_r   <= res.kind;
      out_byte_r   <= res.data_byte;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'd0, out_status_r, out_byte_r};

  // A waiting result is never overwritten by a newly accepted word.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_accept)
    else $error("input accepted over a stalled result");

  // A result produced by an accepted word shows up on the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && res.valid |=> out_valid_r)
    else $error("result lost");

  // A data byte carries a zero status and a final status carries a zero byte.
  a_payload_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == KIND_DATA && out_status_r == 3'd0)
                 || (out_kind_r == KIND_FINAL && out_byte_r == 8'd0))
    else $error("malformed result word");

endmodule
